[sv/tslm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslm_pkg
// Shared widths, types and saturation helper for the two-segment linear model.
// ----------------------------------------------------------------------------
package tslm_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int DATA_W            = 32;
    localparam int AREA_W            = 47;
    localparam int OPER_W            = 34;
    localparam int PROD_W            = 2 * OPER_W;
    localparam int CFG_INDEX_W       = 2;
    localparam int OUT_TDATA_W       = 176;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [OPER_W-1:0] oper_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic        [AREA_W-1:0] area_t;

    localparam prod_t SAT_HI   = (prod_t'(1) <<< (DATA_W - 1)) - prod_t'(1);
    localparam prod_t SAT_LO   = -(prod_t'(1) <<< (DATA_W - 1));
    localparam prod_t AREA_MAX = (prod_t'(1) <<< AREA_W) - prod_t'(1);

    function automatic data_t sat32(input prod_t v);
        if (v > SAT_HI)
            return data_t'(SAT_HI[DATA_W-1:0]);
        else if (v < SAT_LO)
            return data_t'(SAT_LO[DATA_W-1:0]);
        else
            return data_t'(v[DATA_W-1:0]);
    endfunction

endpackage

[sv/tslm_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslm_mul
// Shared signed multiplier with a registered product and its two shifted views.
// ----------------------------------------------------------------------------
module tslm_mul #(
    parameter int FRACTION_BITS = tslm_pkg::FRACTION_BITS_DEF
) (
    input  logic            clk,
    input  tslm_pkg::oper_t a,
    input  tslm_pkg::oper_t b,
    output tslm_pkg::prod_t prod,
    output tslm_pkg::prod_t floor_q,
    output tslm_pkg::prod_t half_q
);
    import tslm_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_t'(a) * prod_t'(b);
    end

    assign prod    = prod_reg;
    assign floor_q = prod_reg >>> FRACTION_BITS;
    assign half_q  = prod_t'(prod_reg >> (FRACTION_BITS + 1));

endmodule

[sv/two_segment_linear_model_with_area_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_segment_linear_model_with_area_top
// Two-segment linear model with running trapezoid area over a point series.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: s_tdata is the time point, s_tlast
// marks the final point of a series. Each input item yields one result item
// on the m_ channel carrying the model value; on the final point it also
// carries the area, final value, peak value and second intercept, and
// m_tlast is set. The four model registers are written through the cfg_
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. One multiplier is shared by every product
// under a small sequencer, so the result of an item is registered once the
// sequencer has stepped through its states; the final point of a series
// takes more states, as it needs three products for the peak. s_tready is
// low meanwhile, so a new item is accepted only once the sequencer is idle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the sequencer holds in its last step until
// the output register is free.
// Reset clears the model registers, the series state and the output valid.
// ----------------------------------------------------------------------------
module two_segment_linear_model_with_area_top #(
    parameter int FRACTION_BITS = tslm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tslm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tslm_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: time_point[31:0].
    input  logic [tslm_pkg::DATA_W-1:0]          s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: model_value[31:0], area[78:32], final_value[110:79],
    // peak_value[142:111], second_intercept[174:143], zero pad [175].
    output logic [tslm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import tslm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_INTERCEPT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_POINT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SLOPE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_SLOPE = 2'd3;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_Y1   = 4'd1;
    localparam logic [3:0] S_MV   = 4'd2;
    localparam logic [3:0] S_SV   = 4'd3;
    localparam logic [3:0] S_FIN  = 4'd4;
    localparam logic [3:0] S_AREA = 4'd5;
    localparam logic [3:0] S_PA   = 4'd6;
    localparam logic [3:0] S_PB   = 4'd7;
    localparam logic [3:0] S_PC   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam int AREA_LO = DATA_W;
    localparam int AREA_HI = AREA_LO + AREA_W - 1;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    data_t intercept_reg;
    data_t change_point_reg;
    data_t first_slope_reg;
    data_t second_slope_reg;

    data_t x_reg;
    logic  last_reg;
    prod_t y1_reg;
    data_t v_reg;
    data_t fin_reg;
    data_t pka_reg;
    prod_t left_reg;
    data_t peak_reg;
    area_t area_sum_reg;
    data_t prev_time_reg;
    data_t prev_value_reg;
    logic  have_prev_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    oper_t mul_a;
    oper_t mul_b;
    prod_t prod;
    prod_t floor_q;
    prod_t half_q;

    logic  below;
    oper_t dx;
    oper_t dx_mag;
    oper_t vs;
    oper_t vs_mag;
    oper_t b0_mag;
    oper_t b1_mag;
    oper_t x0_mag;
    oper_t dxc;
    oper_t dxc_mag;
    prod_t area_sum;
    area_t area_next;
    data_t peak_next;
    logic  out_free;
    logic  out_load;

    tslm_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .a      (mul_a),
        .b      (mul_b),
        .prod   (prod),
        .floor_q(floor_q),
        .half_q (half_q)
    );

    assign below   = x_reg < change_point_reg;
    assign dx      = oper_t'(x_reg) - oper_t'(prev_time_reg);
    assign dx_mag  = dx[OPER_W-1] ? -dx : dx;
    assign vs      = oper_t'(v_reg) + oper_t'(prev_value_reg);
    assign vs_mag  = vs[OPER_W-1] ? -vs : vs;
    assign b0_mag  = first_slope_reg[DATA_W-1] ? -oper_t'(first_slope_reg)
                                               : oper_t'(first_slope_reg);
    assign b1_mag  = second_slope_reg[DATA_W-1] ? -oper_t'(second_slope_reg)
                                                : oper_t'(second_slope_reg);
    assign x0_mag  = change_point_reg[DATA_W-1] ? -oper_t'(change_point_reg)
                                                : oper_t'(change_point_reg);
    assign dxc     = oper_t'(x_reg) - oper_t'(change_point_reg);
    assign dxc_mag = dxc[OPER_W-1] ? -dxc : dxc;

    assign area_sum  = prod_t'({1'b0, area_sum_reg}) + half_q;
    assign area_next = (area_sum > AREA_MAX) ? area_t'(AREA_MAX[AREA_W-1:0])
                                             : area_sum[AREA_W-1:0];

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_Y1:
            begin
                mul_a = oper_t'(first_slope_reg) - oper_t'(second_slope_reg);
                mul_b = oper_t'(change_point_reg);
            end
            S_MV:
            begin
                mul_a = below ? oper_t'(first_slope_reg) : oper_t'(second_slope_reg);
                mul_b = oper_t'(x_reg);
            end
            S_SV:
            begin
                mul_a = oper_t'(second_slope_reg);
                mul_b = oper_t'(x_reg);
            end
            S_FIN:
            begin
                mul_a = dx_mag;
                mul_b = vs_mag;
            end
            S_AREA:
            begin
                mul_a = oper_t'(first_slope_reg);
                mul_b = oper_t'(change_point_reg);
            end
            S_PA:
            begin
                mul_a = b0_mag;
                mul_b = x0_mag;
            end
            S_PB:
            begin
                mul_a = b1_mag;
                mul_b = dxc_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (!first_slope_reg[DATA_W-1] && !second_slope_reg[DATA_W-1])
            peak_next = fin_reg;
        else if (first_slope_reg[DATA_W-1] && second_slope_reg[DATA_W-1])
            peak_next = intercept_reg;
        else if (first_slope_reg > 0 && second_slope_reg[DATA_W-1])
            peak_next = pka_reg;
        else if (left_reg >= prod)
            peak_next = intercept_reg;
        else
            peak_next = fin_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = (s_tvalid) ? S_Y1 : S_IDLE;
            S_Y1:    state_next = S_MV;
            S_MV:    state_next = S_SV;
            S_SV:    state_next = S_FIN;
            S_FIN:   state_next = S_AREA;
            S_AREA:  state_next = last_reg ? S_PA : S_OUT;
            S_PA:    state_next = S_PB;
            S_PB:    state_next = S_PC;
            S_PC:    state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intercept_reg    <= '0;
            change_point_reg <= '0;
            first_slope_reg  <= '0;
            second_slope_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INTERCEPT:    intercept_reg    <= data_t'(cfg_data);
                REG_CHANGE_POINT: change_point_reg <= data_t'(cfg_data);
                REG_FIRST_SLOPE:  first_slope_reg  <= data_t'(cfg_data);
                REG_SECOND_SLOPE: second_slope_reg <= data_t'(cfg_data);
                default:          intercept_reg    <= intercept_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg    <= data_t'(s_tdata);
                last_reg <= s_tlast;
            end
            S_MV:   y1_reg   <= floor_q + prod_t'(intercept_reg);
            S_SV:   v_reg    <= sat32(floor_q + (below ? prod_t'(intercept_reg) : y1_reg));
            S_FIN:  fin_reg  <= sat32(floor_q + y1_reg);
            S_PA:   pka_reg  <= sat32(floor_q + prod_t'(intercept_reg));
            S_PB:   left_reg <= prod;
            S_PC:   peak_reg <= peak_next;
            default: x_reg   <= x_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_sum_reg   <= '0;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            have_prev_reg  <= 1'b0;
        end
        else if (state_reg == S_AREA && have_prev_reg)
        begin
            area_sum_reg <= area_next;
        end
        else if (out_load)
        begin
            if (last_reg)
            begin
                area_sum_reg   <= '0;
                prev_time_reg  <= '0;
                prev_value_reg <= '0;
                have_prev_reg  <= 1'b0;
            end
            else
            begin
                prev_time_reg  <= x_reg;
                prev_value_reg <= v_reg;
                have_prev_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tlast_reg <= last_reg;
            if (last_reg)
                m_tdata_reg <= {1'b0, sat32(y1_reg), peak_reg, fin_reg,
                                area_sum_reg, v_reg};
            else
                m_tdata_reg <= {{(OUT_TDATA_W - DATA_W){1'b0}}, v_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input accepted while a previous item is in progress.");

    a_series_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> (!have_prev_reg && area_sum_reg == '0))
        else $error("Series state not cleared after the final point.");

    a_series_open : assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !last_reg) |=> have_prev_reg)
        else $error("Series state not kept after an inner point.");

    a_area_only_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[AREA_HI:AREA_LO] == '0))
        else $error("Area reported on a point that is not the final one.");

endmodule

[tb/sv/tb_two_segment_linear_model_with_area_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_segment_linear_model_with_area_top
// Self-checking bench for the two-segment linear model with trapezoid area.
// ----------------------------------------------------------------------------
// A table of directed points and register writes runs first: reset values,
// saturating extremes, the area clamp, single-point series, every peak rule
// and a register change in the middle of a series. Random register settings
// and random series follow. Every result item is compared field by field
// with a bit-accurate model kept in the bench, or for typed table rows with
// the values written in the table. Both stream sides idle at random, and
// the receiver holds off once for a long stretch while points keep coming.
// ----------------------------------------------------------------------------
module tb_two_segment_linear_model_with_area_top;

    import tslm_pkg::*;

    localparam int     FRAC            = FRACTION_BITS_DEF;
    localparam int     NUM_REGS        = 4;
    localparam int     RANDOM_ITEMS    = 800;
    localparam int     IDLE_SETTLE     = 16;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     HOLD_OFF_AT     = 300;
    localparam int     CYCLE_LIMIT     = 400000;
    localparam int     PRINT_LIMIT     = 100;
    localparam longint CLAMP_HI        = 64'sd2147483647;
    localparam longint CLAMP_LO        = -64'sd2147483648;
    localparam longint unsigned AREA_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
    localparam data_t  Q_MIN           = 32'sh8000_0000;
    localparam data_t  Q_MAX           = 32'sh7FFF_FFFF;
    localparam data_t  Q_ONE           = 32'sh0001_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INTERCEPT,
        REG_CHANGE_POINT,
        REG_FIRST_SLOPE,
        REG_SECOND_SLOPE
    } reg_index_e;

    typedef enum logic {ROW_CFG, ROW_POINT} row_kind_e;

    typedef struct packed {
        data_t model_value;
        logic  series_done;
        area_t area;
        data_t final_value;
        data_t peak_value;
        data_t second_intercept;
    } point_result_t;

    typedef struct packed {
        row_kind_e     kind;
        reg_index_e    index;
        data_t         operand;
        logic          last;
        logic          typed;
        point_result_t want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    data_t           cur_intercept = '0;
    data_t           cur_change_point = '0;
    data_t           cur_first_slope = '0;
    data_t           cur_second_slope = '0;
    longint          prev_time = 0;
    longint          prev_value = 0;
    longint unsigned area_acc = 0;
    logic            have_prev = 1'b0;

    point_result_t pending_model_results[$];
    plan_row_t     directed_plan[$];

    int  points_sent = 0;
    int  series_sent = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  settings_used = 0;
    int  cycles_run = 0;
    bit  quiet_phase = 1'b0;
    bit  hold_off_req = 1'b0;
    bit  hold_off_done = 1'b0;

    two_segment_linear_model_with_area_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > CLAMP_HI)
            return CLAMP_HI;
        if (v < CLAMP_LO)
            return CLAMP_LO;
        return v;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return longint'(v < 0 ? -v : v);
    endfunction

    // Computes the result of one point and advances the series state.
    function automatic point_result_t model_point(input data_t x_in, input logic last);
        point_result_t   r;
        longint          y0, x0, b0, b1, x, y1, v, yfin, pk;
        longint unsigned left, right;
        y0 = longint'(cur_intercept);
        x0 = longint'(cur_change_point);
        b0 = longint'(cur_first_slope);
        b1 = longint'(cur_second_slope);
        x  = longint'(x_in);
        y1 = (((b0 - b1) * x0) >>> FRAC) + y0;
        if (x < x0)
            v = clamp32(((b0 * x) >>> FRAC) + y0);
        else
            v = clamp32(((b1 * x) >>> FRAC) + y1);
        if (have_prev)
        begin
            area_acc += (magnitude(x - prev_time) * magnitude(v + prev_value)) >> (FRAC + 1);
            if (area_acc > AREA_LIMIT)
                area_acc = AREA_LIMIT;
        end
        r = '0;
        r.model_value = data_t'(v);
        r.series_done = last;
        if (last)
        begin
            yfin = clamp32(((b1 * x) >>> FRAC) + y1);
            if (b0 >= 0 && b1 >= 0)
                pk = yfin;
            else if (b0 < 0 && b1 < 0)
                pk = y0;
            else if (b0 > 0 && b1 < 0)
                pk = clamp32(((b0 * x0) >>> FRAC) + y0);
            else
            begin
                left  = magnitude(b0) * magnitude(x0);
                right = magnitude(b1) * magnitude(x - x0);
                pk = (left >= right) ? y0 : yfin;
            end
            r.area             = area_t'(area_acc);
            r.final_value      = data_t'(yfin);
            r.peak_value       = data_t'(pk);
            r.second_intercept = data_t'(clamp32(y1));
            prev_time  = 0;
            prev_value = 0;
            area_acc   = 0;
            have_prev  = 1'b0;
        end
        else
        begin
            prev_time  = x;
            prev_value = v;
            have_prev  = 1'b1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic data_t rand_span(input int unsigned span);
        return data_t'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    function automatic data_t rand_reg(input reg_index_e idx);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            case ($urandom_range(0, 3))
                0:       return Q_MIN;
                1:       return Q_MAX;
                2:       return '0;
                default: return -data_t'(1);
            endcase
        end
        if (r < 4)
            return data_t'($urandom);
        if (idx == REG_FIRST_SLOPE || idx == REG_SECOND_SLOPE)
            return rand_span(4 * Q_ONE);
        return rand_span(200 * Q_ONE);
    endfunction

    // Most points land near the change point so both segments are hit.
    function automatic data_t rand_point();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return data_t'($urandom);
        if (r < 4)
        begin
            case ($urandom_range(0, 3))
                0:       return Q_MIN;
                1:       return Q_MAX;
                2:       return cur_change_point;
                default: return cur_change_point - data_t'(1);
            endcase
        end
        return cur_change_point + rand_span(100 * Q_ONE);
    endfunction

    function automatic plan_row_t cfg_row(input reg_index_e idx, input data_t value);
        plan_row_t row;
        row = '0;
        row.kind    = ROW_CFG;
        row.index   = idx;
        row.operand = value;
        return row;
    endfunction

    function automatic plan_row_t point_row(input data_t x, input logic last);
        plan_row_t row;
        row = '0;
        row.kind    = ROW_POINT;
        row.operand = x;
        row.last    = last;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input data_t x, input logic last,
                                            input data_t value, input area_t area,
                                            input data_t fin, input data_t peak,
                                            input data_t y1);
        plan_row_t row;
        row = point_row(x, last);
        row.typed                 = 1'b1;
        row.want.model_value      = value;
        row.want.series_done      = last;
        row.want.area             = area;
        row.want.final_value      = fin;
        row.want.peak_value       = peak;
        row.want.second_intercept = y1;
        return row;
    endfunction

    function automatic void add_row(input plan_row_t row);
        directed_plan = {directed_plan, row};
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("result %0d: %s got %h, expected %h", results_seen, what, got_v, want_v);
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_point(input data_t x, input logic last, input logic typed,
                              input point_result_t want);
        int            gap;
        point_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = model_point(x, last);
        if (typed)
            predicted = want;
        pending_model_results = {pending_model_results, predicted};
        points_sent++;
        if (last)
            series_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_model_results.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_e idx, input data_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_INTERCEPT:    cur_intercept    = value;
            REG_CHANGE_POINT: cur_change_point = value;
            REG_FIRST_SLOPE:  cur_first_slope  = value;
            REG_SECOND_SLOPE: cur_second_slope = value;
        endcase
    endtask

    always @(posedge clk)
    begin
        point_result_t seen;
        point_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.model_value      = m_tdata[31:0];
            seen.series_done      = m_tlast;
            seen.area             = m_tdata[78:32];
            seen.final_value      = m_tdata[110:79];
            seen.peak_value       = m_tdata[142:111];
            seen.second_intercept = m_tdata[174:143];
            if (pending_model_results.size() == 0)
                flag_mismatch("unexpected item, model_value",
                              64'(seen.model_value), '0);
            else
            begin
                want = pending_model_results.pop_front();
                if (seen.model_value !== want.model_value)
                    flag_mismatch("model_value", 64'(seen.model_value),
                                  64'(want.model_value));
                if (seen.series_done !== want.series_done)
                    flag_mismatch("series_done", 64'(seen.series_done),
                                  64'(want.series_done));
                if (seen.area !== want.area)
                    flag_mismatch("area", 64'(seen.area), 64'(want.area));
                if (seen.final_value !== want.final_value)
                    flag_mismatch("final_value", 64'(seen.final_value),
                                  64'(want.final_value));
                if (seen.peak_value !== want.peak_value)
                    flag_mismatch("peak_value", 64'(seen.peak_value),
                                  64'(want.peak_value));
                if (seen.second_intercept !== want.second_intercept)
                    flag_mismatch("second_intercept", 64'(seen.second_intercept),
                                  64'(want.second_intercept));
            end
            results_seen++;
        end
    end

    // The receiver stalls at random and holds off once for a long stretch.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("tb_two_segment_linear_model_with_area_top: FAIL");
        $finish;
    end

    initial
    begin
        plan_row_t     row;
        point_result_t no_want;
        int            directed_count;
        int            n_series;
        int            len;
        bit            hold_now;

        no_want = '0;

        // Reset registers give zero everywhere, including a single-point series.
        add_row(typed_row('0, 1'b0, '0, '0, '0, '0, '0));
        add_row(typed_row(Q_MAX, 1'b1, '0, '0, '0, '0, '0));
        add_row(typed_row(Q_MIN, 1'b1, '0, '0, '0, '0, '0));
        // Extreme registers saturate every value and clamp the area.
        add_row(cfg_row(REG_INTERCEPT, Q_MAX));
        add_row(cfg_row(REG_FIRST_SLOPE, Q_MAX));
        add_row(cfg_row(REG_SECOND_SLOPE, Q_MIN));
        add_row(typed_row(Q_MIN, 1'b0, Q_MIN, '0, '0, '0, '0));
        add_row(typed_row(Q_MAX, 1'b0, Q_MIN, '0, '0, '0, '0));
        add_row(typed_row(Q_MIN, 1'b1, Q_MIN, area_t'(AREA_LIMIT),
                          Q_MAX, Q_MAX, Q_MAX));
        // Both slopes non-negative.
        add_row(cfg_row(REG_INTERCEPT, 5 * Q_ONE));
        add_row(cfg_row(REG_CHANGE_POINT, 10 * Q_ONE));
        add_row(cfg_row(REG_FIRST_SLOPE, Q_ONE));
        add_row(cfg_row(REG_SECOND_SLOPE, 2 * Q_ONE));
        add_row(point_row('0, 1'b0));
        add_row(point_row(5 * Q_ONE, 1'b0));
        add_row(point_row(20 * Q_ONE, 1'b1));
        // Both slopes negative.
        add_row(cfg_row(REG_FIRST_SLOPE, -Q_ONE));
        add_row(cfg_row(REG_SECOND_SLOPE, -2 * Q_ONE));
        add_row(point_row(3 * Q_ONE, 1'b1));
        // Mixed signs decided by comparing the two products, both ways.
        add_row(cfg_row(REG_SECOND_SLOPE, Q_ONE));
        add_row(cfg_row(REG_CHANGE_POINT, 4 * Q_ONE));
        add_row(point_row(2 * Q_ONE, 1'b1));
        add_row(point_row(20 * Q_ONE, 1'b1));
        // Flat first slope with equal products at the change point.
        add_row(cfg_row(REG_FIRST_SLOPE, '0));
        add_row(cfg_row(REG_SECOND_SLOPE, -(Q_ONE >>> 1)));
        add_row(point_row(4 * Q_ONE, 1'b1));
        // A register changes between two points of the same series.
        add_row(point_row(7 * Q_ONE, 1'b0));
        add_row(cfg_row(REG_SECOND_SLOPE, 3 * Q_ONE));
        add_row(point_row(9 * Q_ONE, 1'b1));
        add_row(cfg_row(REG_CHANGE_POINT, Q_MIN));
        add_row(cfg_row(REG_INTERCEPT, Q_MIN));
        add_row(point_row(Q_MIN, 1'b1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.index, row.operand);
            end
            else
                send_point(row.operand, row.last, row.typed, row.want);
        end
        directed_count = points_sent;

        while (points_sent < directed_count + RANDOM_ITEMS)
        begin
            settle();
            settings_used++;
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < NUM_REGS; k++)
                if ($urandom_range(0, 1) == 1)
                    write_reg(reg_index_e'(k), rand_reg(reg_index_e'(k)));
            hold_now = 1'b0;
            if (!hold_off_done && points_sent >= HOLD_OFF_AT)
            begin
                hold_off_done = 1'b1;
                hold_off_req  = 1'b1;
                hold_now      = 1'b1;
            end
            // During the long hold enough points follow to back up the input.
            n_series = hold_now ? 6 : $urandom_range(1, 6);
            repeat (n_series)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 8);
                for (int p = 0; p < len; p++)
                    send_point(rand_point(), p == len - 1, 1'b0, no_want);
            end
        end

        settle();
        $display("Checked %0d results from %0d points in %0d series, %0d random settings, %0d cycles.",
                 results_seen, points_sent, series_sent, settings_used, cycles_run);
        $display("Directed extremes, area clamp and every peak rule ran first; the receiver held off for %0d cycles once.",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0)
            $display("tb_two_segment_linear_model_with_area_top: PASS");
        else
            $display("tb_two_segment_linear_model_with_area_top: FAIL");
        $finish;
    end

endmodule

[files.f]
sv/tslm_pkg.sv
sv/tslm_mul.sv
sv/two_segment_linear_model_with_area_top.sv
tb/sv/tb_two_segment_linear_model_with_area_top.sv
